// ===== rtl/lr_pkg.sv =====
// shared types and constants of the line rasterizer
package lr_pkg;

    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ERR_BITS-1:0]   t_err;

    localparam t_coord COORD_ONE = t_coord'(1);

    typedef enum logic [0:0] {
        LR_IDLE,
        LR_RUN
    } t_lr_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic line_nonzero;
        logic step_last;
    } t_dp_status;

endpackage

// ===== rtl/lr_cmd_if.sv =====
// line command channel: start point, end point and ink
interface lr_cmd_if;
    logic             valid;
    logic             ready;
    lr_pkg::t_coord   start_x;
    lr_pkg::t_coord   start_y;
    lr_pkg::t_coord   end_x;
    lr_pkg::t_coord   end_y;
    logic             ink;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, output ink, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, input ink, output ready);
endinterface

// ===== rtl/lr_pix_if.sv =====
// pixel channel: one pixel coordinate per beat
interface lr_pix_if;
    logic             valid;
    logic             ready;
    lr_pkg::t_coord   pixel_x;
    lr_pkg::t_coord   pixel_y;
    logic             pixel_ink;
    logic             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_ink,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_ink,
                    input last_pixel, output ready);
endinterface

// ===== rtl/lr_ctrl.sv =====
// controller of the line rasterizer: command handshake, stepping, pixel valid
module lr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lr_pkg::t_dp_status i_status,
    output lr_pkg::t_dp_cmd    o_cmd
);

    lr_pkg::t_lr_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_load;
    logic              w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lr_pkg::LR_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lr_pkg::LR_IDLE: begin
                if (w_load && i_status.line_nonzero) begin
                    n_state = lr_pkg::LR_RUN;
                end
            end
            lr_pkg::LR_RUN: begin
                if (w_step && i_status.step_last) begin
                    n_state = lr_pkg::LR_IDLE;
                end
            end
            default: n_state = lr_pkg::LR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_step     = 1'b0;
        unique case (r_state)
            lr_pkg::LR_IDLE: begin
                o_in_ready = 1'b1;
            end
            lr_pkg::LR_RUN: begin
                // step only when the pixel register is free or being drained
                w_step = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_load = i_in_valid && o_in_ready;

    always_comb begin
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_load;
    assign o_cmd.step  = w_step;

endmodule

// ===== rtl/lr_datapath.sv =====
// datapath of the line rasterizer: setup, bresenham step and pixel register
module lr_datapath (
    input  logic               i_clk,
    input  lr_pkg::t_dp_cmd    i_cmd,
    input  lr_pkg::t_coord     i_start_x,
    input  lr_pkg::t_coord     i_start_y,
    input  lr_pkg::t_coord     i_end_x,
    input  lr_pkg::t_coord     i_end_y,
    input  logic               i_ink,
    output lr_pkg::t_dp_status o_status,
    output lr_pkg::t_coord     o_pixel_x,
    output lr_pkg::t_coord     o_pixel_y,
    output logic               o_pixel_ink,
    output logic               o_last_pixel
);

    // line state
    lr_pkg::t_coord r_major_pos;
    lr_pkg::t_coord r_minor_pos;
    lr_pkg::t_coord r_major_end;
    lr_pkg::t_err   r_error_term;
    lr_pkg::t_err   r_inc_straight;
    lr_pkg::t_err   r_inc_diagonal;
    logic           r_steep;
    logic           r_major_dec;
    logic           r_minor_dec;
    logic           r_held_ink;

    // pixel register
    lr_pkg::t_coord r_pixel_x;
    lr_pkg::t_coord r_pixel_y;
    logic           r_pixel_ink;
    logic           r_last_pixel;

    // setup
    lr_pkg::t_coord w_dx, w_dy, w_dmaj, w_dmin;
    lr_pkg::t_coord w_mstart, w_mend, w_nstart, w_nend;
    logic           w_steep;
    lr_pkg::t_err   w_inc_s;
    lr_pkg::t_err   w_inc_d;
    lr_pkg::t_err   w_err0;

    always_comb begin
        w_dx    = (i_start_x > i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        w_dy    = (i_start_y > i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        w_steep = w_dx < w_dy;
        if (w_steep) begin
            w_dmaj   = w_dy;
            w_dmin   = w_dx;
            w_mstart = i_start_y;
            w_mend   = i_end_y;
            w_nstart = i_start_x;
            w_nend   = i_end_x;
        end else begin
            w_dmaj   = w_dx;
            w_dmin   = w_dy;
            w_mstart = i_start_x;
            w_mend   = i_end_x;
            w_nstart = i_start_y;
            w_nend   = i_end_y;
        end
        w_inc_s = {1'b0, w_dmin, 1'b0};
        w_inc_d = w_inc_s - {1'b0, w_dmaj, 1'b0};
        w_err0  = w_inc_s - {2'b00, w_dmaj};
    end

    // one step along the major axis
    lr_pkg::t_coord w_major_nxt;
    lr_pkg::t_coord w_minor_nxt;
    lr_pkg::t_err   w_err_nxt;
    logic           w_err_neg;
    logic           w_last;

    always_comb begin
        w_err_neg = r_error_term[lr_pkg::ERR_BITS-1];
        if (w_err_neg) begin
            w_minor_nxt = r_minor_pos;
            w_err_nxt   = r_error_term + r_inc_straight;
        end else begin
            w_minor_nxt = r_minor_dec ? (r_minor_pos - lr_pkg::COORD_ONE)
                                      : (r_minor_pos + lr_pkg::COORD_ONE);
            w_err_nxt   = r_error_term + r_inc_diagonal;
        end
        w_major_nxt = r_major_dec ? (r_major_pos - lr_pkg::COORD_ONE)
                                  : (r_major_pos + lr_pkg::COORD_ONE);
        w_last      = w_major_nxt == r_major_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_major_pos    <= w_mstart;
            r_minor_pos    <= w_nstart;
            r_major_end    <= w_mend;
            r_error_term   <= w_err0;
            r_inc_straight <= w_inc_s;
            r_inc_diagonal <= w_inc_d;
            r_steep        <= w_steep;
            r_major_dec    <= !(w_mend > w_mstart);
            r_minor_dec    <= !(w_nend > w_nstart);
            r_held_ink     <= i_ink;
        end else if (i_cmd.step) begin
            r_major_pos  <= w_major_nxt;
            r_minor_pos  <= w_minor_nxt;
            r_error_term <= w_err_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pixel_x    <= r_steep ? w_minor_nxt : w_major_nxt;
            r_pixel_y    <= r_steep ? w_major_nxt : w_minor_nxt;
            r_pixel_ink  <= r_held_ink;
            r_last_pixel <= w_last;
        end
    end

    assign o_status.line_nonzero = w_mstart != w_mend;
    assign o_status.step_last    = w_last;
    assign o_pixel_x             = r_pixel_x;
    assign o_pixel_y             = r_pixel_y;
    assign o_pixel_ink           = r_pixel_ink;
    assign o_last_pixel          = r_last_pixel;

endmodule

// ===== rtl/line_rasterizer.sv =====
// top level of the line rasterizer: controller and datapath
// Takes one line command per beat on i_cmd and emits the pixels of the line on o_pix, one
// beat per step along the major axis, start point left out and end point flagged with
// last_pixel. A command is taken while idle and its line of N major-axis steps then
// occupies the single stepping datapath, one pixel per cycle while the sink keeps ready
// high, and no new command is taken until the final step of the line.
// The next command is taken in the cycle after the final pixel enters the output register,
// while that pixel still waits to be taken. A zero-length line is taken and gives no pixel.
module line_rasterizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lr_cmd_if.sink     i_cmd,
    lr_pix_if.source   o_pix
);

    lr_pkg::t_dp_cmd    w_cmd;
    lr_pkg::t_dp_status w_status;

    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_start_x    (i_cmd.start_x),
        .i_start_y    (i_cmd.start_y),
        .i_end_x      (i_cmd.end_x),
        .i_end_y      (i_cmd.end_y),
        .i_ink        (i_cmd.ink),
        .o_status     (w_status),
        .o_pixel_x    (o_pix.pixel_x),
        .o_pixel_y    (o_pix.pixel_y),
        .o_pixel_ink  (o_pix.pixel_ink),
        .o_last_pixel (o_pix.last_pixel)
    );

endmodule

// ===== rtl/lr_checker.sv =====
// port-level checks of the line rasterizer and their bind
module lr_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  logic           i_cmd_ready,
    input  lr_pkg::t_coord i_start_x,
    input  lr_pkg::t_coord i_start_y,
    input  lr_pkg::t_coord i_end_x,
    input  lr_pkg::t_coord i_end_y,
    input  logic           i_pix_valid,
    input  logic           i_pix_ready,
    input  lr_pkg::t_coord i_pixel_x,
    input  lr_pkg::t_coord i_pixel_y,
    input  logic           i_pixel_ink,
    input  logic           i_last_pixel
);

    logic w_cmd_beat;
    logic w_zero_len;

    assign w_cmd_beat = i_cmd_valid && i_cmd_ready;
    assign w_zero_len = (i_start_x == i_end_x) && (i_start_y == i_end_y);

    // a stalled pixel beat holds
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pixel_x)
            && $stable(i_pixel_y) && $stable(i_pixel_ink) && $stable(i_last_pixel))
        else $error("pixel beat changed while stalled");

    // a real line blocks the command channel
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_beat && !w_zero_len |=> !i_cmd_ready)
        else $error("command taken while a line is in progress");

    // a zero-length line leaves the block ready, only an earlier end point may still wait
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_beat && w_zero_len |=> i_cmd_ready && (!i_pix_valid || i_last_pixel))
        else $error("zero-length line was not dropped");

    // a pending pixel that is not the end point means the line is still running
    a_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_last_pixel |-> !i_cmd_ready)
        else $error("command ready before the end point");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_start_x    (i_cmd.start_x),
    .i_start_y    (i_cmd.start_y),
    .i_end_x      (i_cmd.end_x),
    .i_end_y      (i_cmd.end_y),
    .i_pix_valid  (o_pix.valid),
    .i_pix_ready  (o_pix.ready),
    .i_pixel_x    (o_pix.pixel_x),
    .i_pixel_y    (o_pix.pixel_y),
    .i_pixel_ink  (o_pix.pixel_ink),
    .i_last_pixel (o_pix.last_pixel)
);
